FILE: sv/psipp_pkg.sv
// psipp_pkg: types, codes and constants of the psi section parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package psipp_pkg;

  localparam int SECTION_BYTES = 1024;
  localparam int MAX_SERVICES  = 32;
  localparam int SEC_AW  = $clog2(SECTION_BYTES);
  localparam int LEN_W   = $clog2(SECTION_BYTES + 2);
  localparam int SVC_AW  = $clog2(MAX_SERVICES);
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 5;
  localparam int POS_W   = 13;
  localparam int LEFT_W  = 14;
  localparam int KCNT_W  = 3;

  localparam logic [12:0] PID_NONE = 13'h1fff;

  localparam logic [7:0] ST_MPEG1_VIDEO = 8'h01;
  localparam logic [7:0] ST_MPEG2_VIDEO = 8'h02;
  localparam logic [7:0] ST_H264_VIDEO  = 8'h1b;
  localparam logic [7:0] ST_MPEG1_AUDIO = 8'h03;
  localparam logic [7:0] ST_MPEG2_AUDIO = 8'h04;
  localparam logic [7:0] ST_AC3_AUDIO   = 8'h81;
  localparam logic [7:0] ST_EAC3_AUDIO  = 8'h6a;
  localparam logic [7:0] ST_PES_PRIV    = 8'h06;

  localparam logic [1:0] REQ_PAT   = 2'd0;
  localparam logic [1:0] REQ_PMT   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [2:0] STAT_PARSED  = 3'd0;
  localparam logic [2:0] STAT_REJECT  = 3'd1;
  localparam logic [2:0] STAT_BAD     = 3'd2;
  localparam logic [2:0] STAT_READ    = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

  typedef enum logic [2:0] {
    CMD_PAT,
    CMD_PMT,
    CMD_CLEAR,
    CMD_READ,
    CMD_OVER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [LEN_W-1:0]   len;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [SEC_AW-1:0] addr;
    logic [7:0]        data;
  } sec_wr_t;

  typedef struct packed {
    logic [15:0] program_number;
    logic [12:0] pmt_pid;
    logic [12:0] video_pid;
    logic [12:0] audio_pid;
    logic        video_kind;
    logic        audio_kind;
    logic        pmt_done;
  } svc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_A,
    S_HDR_D,
    S_TBL_A,
    S_TBL_D,
    S_PAT_CHK,
    S_PAT_A,
    S_PAT_D,
    S_PAT_ADD,
    S_PMT_CHK,
    S_PMT_A,
    S_PMT_D,
    S_PMT_USE,
    S_PMT_WR
  } state_t;

  function automatic logic [SEC_AW-1:0] hdr_addr(input logic [KCNT_W-1:0] k);
    logic [SEC_AW-1:0] a;
    case (k)
      3'd0:    a = SEC_AW'(1);
      3'd1:    a = SEC_AW'(2);
      3'd2:    a = SEC_AW'(5);
      3'd3:    a = SEC_AW'(10);
      default: a = SEC_AW'(11);
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: sv/psi_pat_pmt_section_parser.sv
// psi_pat_pmt_section_parser: top level of the pat/pmt section parser
// depends on psipp_pkg, psipp_front, psipp_cmdq and psipp_back
`timescale 1ns / 1ps
`default_nettype none
// usage
//  - input channel: a word is taken at a rising edge with start high and busy low
//  - pat/pmt byte words load the section store, one word per cycle while busy is low,
//    no result until the word flagged last_byte
//  - the last byte, a clear or a read turns into a command for the parse engine;
//    busy stays high until its result has been issued
//  - result channel: out_valid strobes for exactly one cycle per result; the
//    receiver cannot stall it, so results are never held back
//  - clear, overlong and bad index are answered from the idle state as the command
//    is taken from the queue; a read first passes the table address and data states
//  - after the last byte a pat walk reads the header and then each entry (ending
//    after the header when it is rejected), a pmt walk the header, the table entry
//    and then each elementary stream: each byte is one access to the read port of
//    the section store, address then data
//  - throughput: one section byte per cycle while loading and busy is low
//  - reset (synchronous, rst_n low) empties the command queue, returns the
//    engine to idle and sets the service count and byte count to zero; store
//    and table contents are not cleared
module psi_pat_pmt_section_parser
  import psipp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_last_byte,
  input  wire logic [IDX_W-1:0] in_service_index,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [CNT_W-1:0]      out_service_count,
  output logic [15:0]           out_program_number,
  output logic [12:0]           out_pmt_pid,
  output logic [12:0]           out_video_pid,
  output logic [12:0]           out_audio_pid,
  output logic                  out_video_kind,
  output logic                  out_audio_kind,
  output logic                  out_pmt_done
);

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  sec_wr_t sec_wr;
  // queue to back
  cmd_t    head;
  logic    q_empty, q_full, pop;
  logic    back_busy;

  // word intake and byte counting
  psipp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_service_index (in_service_index),
    .q_empty          (q_empty),
    .q_full           (q_full),
    .back_busy        (back_busy),
    .push             (push),
    .push_cmd         (push_cmd),
    .sec_wr           (sec_wr)
  );

  // decouples intake from the parse engine
  psipp_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // section store, service table and walk sequencer
  psipp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .sec_wr             (sec_wr),
    .head               (head),
    .q_empty            (q_empty),
    .pop                (pop),
    .back_busy          (back_busy),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_service_count  (out_service_count),
    .out_program_number (out_program_number),
    .out_pmt_pid        (out_pmt_pid),
    .out_video_pid      (out_video_pid),
    .out_audio_pid      (out_audio_pid),
    .out_video_kind     (out_video_kind),
    .out_audio_kind     (out_audio_kind),
    .out_pmt_done       (out_pmt_done)
  );

  // a clear always answers, through the queue and the result register, with a zero count
  a_clear_answer : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == REQ_CLEAR) |=> ##1
      (out_valid && (out_status == STAT_CLEARED) && (out_service_count == '0)))
    else $error("clear not answered");

  // a plain section byte never produces a result
  a_byte_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_byte &&
      ((in_req_type == REQ_PAT) || (in_req_type == REQ_PMT)) |=> !out_valid)
    else $error("result from a non-final byte");

  // service count never exceeds the table size
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_service_count <= CNT_W'(MAX_SERVICES)))
    else $error("service count overflow");

  // one command in flight: results are never back to back
  a_single_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back results");

endmodule
`default_nettype wire

FILE: sv/psipp_front.sv
// psipp_front: takes words, counts section bytes and queues parse commands
// depends on psipp_pkg
`timescale 1ns / 1ps
`default_nettype none
module psipp_front
  import psipp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_last_byte,
  input  wire logic [IDX_W-1:0] in_service_index,
  input  wire logic             q_empty,
  input  wire logic             q_full,
  input  wire logic             back_busy,
  output logic                  push,
  output cmd_t                  push_cmd,
  output sec_wr_t               sec_wr
);

  logic [LEN_W-1:0] rcv_r, rcv_nxt;
  logic             take;
  logic [LEN_W-1:0] len_now;

  assign busy = !q_empty || q_full || back_busy;
  assign take = start && !busy;

  always_comb begin
    rcv_nxt       = rcv_r;
    push          = 1'b0;
    push_cmd.kind = CMD_CLEAR;
    push_cmd.len  = rcv_r;
    push_cmd.idx  = in_service_index;
    sec_wr.en     = 1'b0;
    sec_wr.addr   = rcv_r[SEC_AW-1:0];
    sec_wr.data   = in_data_byte;
    len_now       = LEN_W'(SECTION_BYTES + 1);
    if (take) begin
      case (in_req_type)
        REQ_CLEAR: begin
          push          = 1'b1;
          push_cmd.kind = CMD_CLEAR;
        end
        REQ_READ: begin
          push          = 1'b1;
          push_cmd.kind = CMD_READ;
        end
        default: begin
          if (rcv_r < LEN_W'(SECTION_BYTES)) begin
            sec_wr.en = 1'b1;
            len_now   = rcv_r + LEN_W'(1);
          end
          rcv_nxt = len_now;
          if (in_last_byte) begin
            rcv_nxt      = '0;
            push         = 1'b1;
            push_cmd.len = len_now;
            if (len_now > LEN_W'(SECTION_BYTES)) begin
              push_cmd.kind = CMD_OVER;
            end else if (in_req_type == REQ_PAT) begin
              push_cmd.kind = CMD_PAT;
            end else begin
              push_cmd.kind = CMD_PMT;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcv_r <= '0;
    end else begin
      rcv_r <= rcv_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/psipp_cmdq.sv
// psipp_cmdq: two-entry command queue between front and back
// depends on psipp_pkg
`timescale 1ns / 1ps
`default_nettype none
module psipp_cmdq
  import psipp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign head    = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

FILE: sv/psipp_back.sv
// psipp_back: section store, service table and the pat/pmt walk sequencer
// depends on psipp_pkg
`timescale 1ns / 1ps
`default_nettype none
module psipp_back
  import psipp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  sec_wr_t          sec_wr,
  input  cmd_t             head,
  input  wire logic        q_empty,
  output logic             pop,
  output logic             back_busy,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [CNT_W-1:0] out_service_count,
  output logic [15:0]      out_program_number,
  output logic [12:0]      out_pmt_pid,
  output logic [12:0]      out_video_pid,
  output logic [12:0]      out_audio_pid,
  output logic             out_video_kind,
  output logic             out_audio_kind,
  output logic             out_pmt_done
);

  logic [7:0] sec_mem [SECTION_BYTES];
  svc_t       tbl_mem [MAX_SERVICES];
  logic [7:0] sec_rd_r;
  svc_t       tbl_rd_r;
  logic [SEC_AW-1:0] sec_raddr;
  logic              tbl_we;
  logic [SVC_AW-1:0] tbl_waddr;
  svc_t              tbl_wdata;

  state_t state_r, state_nxt;
  cmd_kind_t kind_r, kind_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [KCNT_W-1:0] k_r, k_nxt;
  logic [4:0][7:0]   hb_r, hb_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic signed [LEFT_W-1:0] left_r, left_nxt;
  logic ok_r, ok_nxt;
  logic aseen_r, aseen_nxt;
  svc_t entry_r, entry_nxt;
  logic [2:0] status_r, status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             ov_r, ov_nxt;
  logic [2:0]       ost_r, ost_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  svc_t             oent_r, oent_nxt;

  // header, entry and stream fields decoded from the shifted section bytes
  logic             hdr_ok;
  logic [POS_W-1:0] pmt_pos0;
  logic             idx_ok;
  logic             pat_more;
  logic [7:0]       st;
  logic [12:0]      es_pid;
  logic [POS_W-1:0] es_step;
  logic [15:0]      prog;
  logic             is_video, is_audio;

  assign back_busy = (state_r != S_IDLE);
  assign idx_ok    = (CNT_W'(head.idx) < count_r);
  assign hdr_ok    = (len_r >= LEN_W'(12)) && hb_r[3][7] && hb_r[1][0];
  assign pmt_pos0  = POS_W'({hb_r[0][3:0], sec_rd_r}) + POS_W'(12);
  assign pat_more  = (left_r >= LEFT_W'(4)) &&
                     (LEFT_W'(pos_r) + LEFT_W'(4) <= LEFT_W'(len_r));
  assign st        = hb_r[4];
  assign es_pid    = {hb_r[3][4:0], hb_r[2]};
  assign es_step   = POS_W'({hb_r[1][3:0], hb_r[0]}) + POS_W'(5);
  assign prog      = {hb_r[3], hb_r[2]};
  assign is_video  = (st == ST_MPEG1_VIDEO) || (st == ST_MPEG2_VIDEO) || (st == ST_H264_VIDEO);
  assign is_audio  = (st == ST_MPEG1_AUDIO) || (st == ST_MPEG2_AUDIO) || (st == ST_AC3_AUDIO) ||
                     (st == ST_EAC3_AUDIO) || (st == ST_PES_PRIV);

  assign sec_raddr = (state_r == S_HDR_A) ? hdr_addr(k_r)
                                          : SEC_AW'(pos_r) + SEC_AW'(k_r);

  always_ff @(posedge clk) begin
    if (sec_wr.en) begin
      sec_mem[sec_wr.addr] <= sec_wr.data;
    end
    sec_rd_r <= sec_mem[sec_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_r <= tbl_mem[idx_r[SVC_AW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            CMD_PAT:  state_nxt = S_HDR_A;
            CMD_PMT:  state_nxt = idx_ok ? S_HDR_A : S_IDLE;
            CMD_READ: state_nxt = idx_ok ? S_TBL_A : S_IDLE;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_HDR_A: state_nxt = S_HDR_D;
      S_HDR_D: begin
        if (k_r != KCNT_W'(4)) begin
          state_nxt = S_HDR_A;
        end else if (kind_r == CMD_PAT) begin
          state_nxt = hdr_ok ? S_PAT_CHK : S_IDLE;
        end else begin
          state_nxt = S_TBL_A;
        end
      end
      S_TBL_A: state_nxt = S_TBL_D;
      S_TBL_D: begin
        if (kind_r == CMD_READ) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = ok_r ? S_PMT_CHK : S_PMT_WR;
        end
      end
      S_PAT_CHK: state_nxt = pat_more ? S_PAT_A : S_IDLE;
      S_PAT_A:   state_nxt = S_PAT_D;
      S_PAT_D:   state_nxt = (k_r == KCNT_W'(3)) ? S_PAT_ADD : S_PAT_A;
      S_PAT_ADD: state_nxt = S_PAT_CHK;
      S_PMT_CHK: state_nxt = (left_r >= LEFT_W'(5)) ? S_PMT_A : S_PMT_WR;
      S_PMT_A:   state_nxt = S_PMT_D;
      S_PMT_D:   state_nxt = (k_r == KCNT_W'(4)) ? S_PMT_USE : S_PMT_A;
      S_PMT_USE: state_nxt = S_PMT_CHK;
      S_PMT_WR:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    hb_nxt     = hb_r;
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    ok_nxt     = ok_r;
    aseen_nxt  = aseen_r;
    entry_nxt  = entry_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    ocnt_nxt   = ocnt_r;
    oent_nxt   = oent_r;
    pop        = 1'b0;
    tbl_we     = 1'b0;
    tbl_waddr  = idx_r[SVC_AW-1:0];
    tbl_wdata  = entry_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          kind_nxt = head.kind;
          len_nxt  = head.len;
          idx_nxt  = head.idx;
          k_nxt    = '0;
          ocnt_nxt = count_r;
          oent_nxt = '0;
          case (head.kind)
            CMD_CLEAR: begin
              count_nxt = '0;
              ocnt_nxt  = '0;
              ov_nxt    = 1'b1;
              ost_nxt   = STAT_CLEARED;
            end
            CMD_OVER: begin
              ov_nxt  = 1'b1;
              ost_nxt = STAT_BAD;
            end
            CMD_PAT: begin
            end
            default: begin
              if (!idx_ok) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_BAD;
              end
            end
          endcase
        end
      end
      S_HDR_D: begin
        hb_nxt = {hb_r[3:0], sec_rd_r};
        k_nxt  = k_r + KCNT_W'(1);
        if (k_r == KCNT_W'(4)) begin
          k_nxt  = '0;
          ok_nxt = hdr_ok;
          if (kind_r == CMD_PAT) begin
            pos_nxt  = POS_W'(8);
            left_nxt = $signed(LEFT_W'({hb_r[3][3:0], hb_r[2]})) - LEFT_W'(9);
            if (!hdr_ok) begin
              ov_nxt   = 1'b1;
              ost_nxt  = STAT_REJECT;
              ocnt_nxt = count_r;
              oent_nxt = '0;
            end
          end else begin
            pos_nxt  = pmt_pos0;
            left_nxt = $signed(LEFT_W'(len_r)) - $signed(LEFT_W'(pmt_pos0)) - LEFT_W'(4);
          end
        end
      end
      S_TBL_D: begin
        entry_nxt = tbl_rd_r;
        if (kind_r == CMD_READ) begin
          ov_nxt   = 1'b1;
          ost_nxt  = STAT_READ;
          ocnt_nxt = count_r;
          oent_nxt = tbl_rd_r;
        end else begin
          entry_nxt.pmt_done = 1'b1;
          status_nxt = ok_r ? STAT_PARSED : STAT_REJECT;
          aseen_nxt  = 1'b0;
        end
      end
      S_PAT_CHK: begin
        k_nxt = '0;
        if (!pat_more) begin
          ov_nxt   = 1'b1;
          ost_nxt  = STAT_PARSED;
          ocnt_nxt = count_r;
          oent_nxt = '0;
        end
      end
      S_PAT_D: begin
        hb_nxt = {hb_r[3:0], sec_rd_r};
        k_nxt  = k_r + KCNT_W'(1);
      end
      S_PAT_ADD: begin
        // new service appended while the table has room and the program number is not zero
        if ((count_r < CNT_W'(MAX_SERVICES)) && (prog != 16'd0)) begin
          tbl_we                   = 1'b1;
          tbl_waddr                = count_r[SVC_AW-1:0];
          tbl_wdata.program_number = prog;
          tbl_wdata.pmt_pid        = {hb_r[1][4:0], hb_r[0]};
          tbl_wdata.video_pid      = PID_NONE;
          tbl_wdata.audio_pid      = PID_NONE;
          tbl_wdata.video_kind     = 1'b0;
          tbl_wdata.audio_kind     = 1'b0;
          tbl_wdata.pmt_done       = 1'b0;
          count_nxt                = count_r + CNT_W'(1);
        end
        pos_nxt  = pos_r + POS_W'(4);
        left_nxt = left_r - LEFT_W'(4);
      end
      S_PMT_CHK: begin
        k_nxt = '0;
      end
      S_PMT_D: begin
        hb_nxt = {hb_r[3:0], sec_rd_r};
        k_nxt  = k_r + KCNT_W'(1);
      end
      S_PMT_USE: begin
        // last video stream wins, first audio stream wins
        if (is_video) begin
          entry_nxt.video_pid  = es_pid;
          entry_nxt.video_kind = (st != ST_H264_VIDEO);
        end else if (is_audio && !aseen_r) begin
          entry_nxt.audio_pid  = es_pid;
          entry_nxt.audio_kind = (st == ST_MPEG1_AUDIO) || (st == ST_MPEG2_AUDIO);
          aseen_nxt            = 1'b1;
        end
        pos_nxt  = pos_r + es_step;
        left_nxt = left_r - $signed(LEFT_W'(es_step));
      end
      S_PMT_WR: begin
        tbl_we   = 1'b1;
        ov_nxt   = 1'b1;
        ost_nxt  = status_r;
        ocnt_nxt = count_r;
        oent_nxt = entry_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    len_r    <= len_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    hb_r     <= hb_nxt;
    pos_r    <= pos_nxt;
    left_r   <= left_nxt;
    ok_r     <= ok_nxt;
    aseen_r  <= aseen_nxt;
    entry_r  <= entry_nxt;
    status_r <= status_nxt;
    ost_r    <= ost_nxt;
    ocnt_r   <= ocnt_nxt;
    oent_r   <= oent_nxt;
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_service_count  = ocnt_r;
  assign out_program_number = oent_r.program_number;
  assign out_pmt_pid        = oent_r.pmt_pid;
  assign out_video_pid      = oent_r.video_pid;
  assign out_audio_pid      = oent_r.audio_pid;
  assign out_video_kind     = oent_r.video_kind;
  assign out_audio_kind     = oent_r.audio_kind;
  assign out_pmt_done       = oent_r.pmt_done;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// testbench for psi_pat_pmt_section_parser: pat/pmt sections, clears and reads
// depends on psipp_pkg and the parser rtl; self-checking against an inline predictor
`timescale 1ns / 1ps
module testbench;
  import psipp_pkg::*;

  // one input word as the driver presents it, plus its pacing controls
  typedef struct {
    logic [1:0] req;
    logic [7:0] data;
    logic       last;
    logic [4:0] idx;
    int         idle;   // percent chance of a gap before this word
    bit         drain;  // hold this word until every answer is back
  } word_t;

  // one parser answer as it appears on the out_ ports
  typedef struct packed {
    logic [2:0]       status;
    logic [CNT_W-1:0] count;
    svc_t             e;
  } answer_t;

  localparam int QUIET_LIMIT = 20000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [1:0]       in_req_type = REQ_READ;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_last_byte = 1'b0;
  logic [IDX_W-1:0] in_service_index = '0;
  logic             busy, out_valid, out_video_kind, out_audio_kind, out_pmt_done;
  logic [2:0]       out_status;
  logic [CNT_W-1:0] out_service_count;
  logic [15:0]      out_program_number;
  logic [12:0]      out_pmt_pid, out_video_pid, out_audio_pid;

  psi_pat_pmt_section_parser dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte), .in_service_index(in_service_index),
    .out_valid(out_valid), .out_status(out_status),
    .out_service_count(out_service_count), .out_program_number(out_program_number),
    .out_pmt_pid(out_pmt_pid), .out_video_pid(out_video_pid),
    .out_audio_pid(out_audio_pid), .out_video_kind(out_video_kind),
    .out_audio_kind(out_audio_kind), .out_pmt_done(out_pmt_done)
  );

  word_t      pending_words[$];
  answer_t    awaited_answers[$];
  logic [7:0] sec[$];            // section under construction

  // predictor state: section store, byte count, service table
  logic [7:0] sect_mem[SECTION_BYTES];
  int         sect_len;
  int         svc_count;
  svc_t       svc_tab[MAX_SERVICES];

  int errors = 0;
  int words_sent = 0;
  int answers_seen = 0;
  int quiet = 0;
  int est_count = 0;             // rough service count while building stimulus
  int built_results = 0;

  initial forever #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit header_good(int len);
    return len >= 12 && sect_mem[1][7] && sect_mem[5][0];
  endfunction

  // pat walk: 4-byte entries from byte 8, clamped to the received bytes
  function automatic logic [2:0] walk_pat(int len);
    int          left, pos;
    logic [15:0] prog;
    logic [12:0] pid;
    if (!header_good(len)) return STAT_REJECT;
    left = int'({sect_mem[1][3:0], sect_mem[2]}) - 9;
    pos = 8;
    while (left >= 4 && pos + 4 <= len) begin
      prog = {sect_mem[pos], sect_mem[pos+1]};
      pid = {sect_mem[pos+2][4:0], sect_mem[pos+3]};
      if (svc_count < MAX_SERVICES && prog != 16'd0) begin
        svc_tab[svc_count] = '{prog, pid, PID_NONE, PID_NONE, 1'b0, 1'b0, 1'b0};
        svc_count++;
      end
      pos += 4;
      left -= 4;
    end
    return STAT_PARSED;
  endfunction

  // pmt walk: last video stream wins, first audio stream wins
  function automatic logic [2:0] walk_pmt(int len, int idx);
    int          left, pos, step;
    bit          audio_seen;
    logic [7:0]  st;
    logic [12:0] pid;
    audio_seen = 1'b0;
    svc_tab[idx].pmt_done = 1'b1;   // marked even when the header is rejected
    if (!header_good(len)) return STAT_REJECT;
    pos = int'({sect_mem[10][3:0], sect_mem[11]}) + 12;
    left = len - pos - 4;
    while (left >= 5) begin
      st = sect_mem[pos];
      pid = {sect_mem[pos+1][4:0], sect_mem[pos+2]};
      step = int'({sect_mem[pos+3][3:0], sect_mem[pos+4]}) + 5;
      case (st)
        ST_MPEG1_VIDEO, ST_MPEG2_VIDEO, ST_H264_VIDEO: begin
          svc_tab[idx].video_pid = pid;
          svc_tab[idx].video_kind = (st != ST_H264_VIDEO);
        end
        ST_MPEG1_AUDIO, ST_MPEG2_AUDIO, ST_AC3_AUDIO, ST_EAC3_AUDIO, ST_PES_PRIV: begin
          if (!audio_seen) begin
            svc_tab[idx].audio_pid = pid;
            svc_tab[idx].audio_kind = (st == ST_MPEG1_AUDIO || st == ST_MPEG2_AUDIO);
            audio_seen = 1'b1;
          end
        end
        default: ;
      endcase
      left -= step;
      pos += step;
    end
    return STAT_PARSED;
  endfunction

  // advance the predictor by one accepted word; returns 1 when an answer is due
  function automatic bit predict_answer(word_t w, output answer_t a);
    int len;
    a = '0;
    if (w.req == REQ_CLEAR) begin
      svc_count = 0;
      a.status = STAT_CLEARED;
      return 1'b1;
    end
    if (w.req == REQ_READ) begin
      if (int'(w.idx) < svc_count) begin
        a.status = STAT_READ;
        a.e = svc_tab[w.idx];
      end else a.status = STAT_BAD;
      a.count = svc_count;
      return 1'b1;
    end
    // section byte: store it, saturate the count once the store is full
    if (sect_len < SECTION_BYTES) begin
      sect_mem[sect_len] = w.data;
      sect_len++;
    end else sect_len = SECTION_BYTES + 1;
    if (!w.last) return 1'b0;
    len = sect_len;
    sect_len = 0;
    if (len > SECTION_BYTES) a.status = STAT_BAD;
    else if (w.req == REQ_PAT) a.status = walk_pat(len);
    else if (int'(w.idx) < svc_count) begin
      a.status = walk_pmt(len, w.idx);
      a.e = svc_tab[w.idx];
    end else a.status = STAT_BAD;
    a.count = svc_count;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic put_word(logic [1:0] req, logic [7:0] data, logic last,
                          logic [4:0] idx, int idle, bit drain);
    word_t w;
    w = '{req, data, last, idx, idle, drain};
    pending_words.push_back(w);
    if (req == REQ_CLEAR || req == REQ_READ || last) built_results++;
  endtask

  // pat section with n program entries; program number 0 now and then
  task automatic build_pat(int n);
    int sl;
    sl = 5 + 4 * n + 4;
    sec = {};
    sec.push_back(8'h00);
    sec.push_back({1'b1, 3'($urandom), 4'(sl >> 8)});
    sec.push_back(8'(sl));
    repeat (2) sec.push_back(8'($urandom));
    sec.push_back({7'($urandom), 1'b1});
    repeat (2) sec.push_back(8'($urandom));
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        sec.push_back(8'h00);
        sec.push_back(8'h00);
      end else begin
        sec.push_back(8'($urandom));
        sec.push_back(8'($urandom));
      end
      sec.push_back(8'($urandom));
      sec.push_back(8'($urandom));
    end
    repeat (4) sec.push_back(8'($urandom));   // crc, not checked by the block
  endtask

  function automatic logic [7:0] pick_stream_type();
    case ($urandom_range(0, 11))
      0: return ST_MPEG1_VIDEO;
      1: return ST_MPEG2_VIDEO;
      2, 3: return ST_H264_VIDEO;
      4: return ST_MPEG1_AUDIO;
      5: return ST_MPEG2_AUDIO;
      6: return ST_AC3_AUDIO;
      7: return ST_EAC3_AUDIO;
      8: return ST_PES_PRIV;
      default: return 8'($urandom);
    endcase
  endfunction

  // pmt section with nes elementary streams; types given or random
  task automatic build_pmt(int nes, logic [7:0] types[$]);
    int pil, esl, sl;
    sec = {};
    sec.push_back(8'h02);
    sec.push_back(8'h00);
    sec.push_back(8'h00);
    repeat (2) sec.push_back(8'($urandom));
    sec.push_back({7'($urandom), 1'b1});
    repeat (4) sec.push_back(8'($urandom));
    pil = $urandom_range(0, 5);
    sec.push_back({4'($urandom), 4'h0});
    sec.push_back(8'(pil));
    repeat (pil) sec.push_back(8'($urandom));
    for (int i = 0; i < nes; i++) begin
      esl = $urandom_range(0, 3);
      sec.push_back(i < types.size() ? types[i] : pick_stream_type());
      sec.push_back(8'($urandom));
      sec.push_back(8'($urandom));
      sec.push_back({4'($urandom), 4'h0});
      sec.push_back(8'(esl));
      repeat (esl) sec.push_back(8'($urandom));
    end
    repeat (4) sec.push_back(8'($urandom));
    sl = sec.size() - 3;
    sec[1] = {1'b1, 3'($urandom), 4'(sl >> 8)};
    sec[2] = 8'(sl);
  endtask

  // occasional damage: header bits, short sections, lying section_length
  task automatic damage_section();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: sec[1][7] = 1'b0;
      1: sec[5][0] = 1'b0;
      2: while (sec.size() > $urandom_range(1, 11)) void'(sec.pop_back());
      3: begin
        sec[1][3:0] = 4'($urandom);
        sec[2] = 8'($urandom);
      end
      4: if (sec.size() > 16) repeat ($urandom_range(1, 4)) void'(sec.pop_back());
      default: ;
    endcase
  endtask

  // send the built section; with mix set, early bytes carry either byte type
  task automatic send_section(logic [1:0] req, logic [4:0] idx, int idle, bit mix);
    logic [1:0] r;
    for (int i = 0; i < sec.size(); i++) begin
      r = (mix && i != sec.size() - 1) ? 2'($urandom_range(0, 1)) : req;
      put_word(r, sec[i], i == sec.size() - 1, i == sec.size() - 1 ? idx : 5'($urandom),
               idle, 1'b0);
    end
  endtask

  function automatic logic [4:0] pick_index();
    if (est_count > 0 && $urandom_range(0, 4) != 0)
      return 5'($urandom_range(0, est_count - 1));
    return 5'($urandom);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    word_t  w;
    answer_t a;
    logic   next_start;
    next_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        words_sent++;
        w.req = in_req_type;
        w.data = in_data_byte;
        w.last = in_last_byte;
        w.idx = in_service_index;
        if (predict_answer(w, a)) awaited_answers.push_back(a);
        next_start = 1'b0;
      end
      if (!(start && busy) && pending_words.size() > 0) begin
        w = pending_words[0];
        if (!(w.drain && awaited_answers.size() > 0) && $urandom_range(0, 99) >= w.idle)
        begin
          void'(pending_words.pop_front());
          in_req_type <= w.req;
          in_data_byte <= w.data;
          in_last_byte <= w.last;
          in_service_index <= w.idx;
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $realtime, out_status);
        errors++;
      end else begin
        a = awaited_answers.pop_front();
        answers_seen++;
        check_field("status", a.status, out_status);
        check_field("service_count", a.count, out_service_count);
        check_field("program_number", a.e.program_number, out_program_number);
        check_field("pmt_pid", a.e.pmt_pid, out_pmt_pid);
        check_field("video_pid", a.e.video_pid, out_video_pid);
        check_field("audio_pid", a.e.audio_pid, out_audio_pid);
        check_field("video_kind", a.e.video_kind, out_video_kind);
        check_field("audio_kind", a.e.audio_kind, out_audio_kind);
        check_field("pmt_done", a.e.pmt_done, out_pmt_done);
      end
    end
    // watchdog on cycles where nothing moves on either channel
    if (!rst_n || (start && !busy) || out_valid) quiet <= 0;
    else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("[FAIL] regression broken");
      $finish;
    end else quiet <= quiet + 1;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [7:0] types[$];
    int idle_of_phase[4] = '{0, 54, 0, 9};
    int start_words, start_results, half;

    sect_len = 0;
    svc_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    put_word(REQ_READ, 8'hff, 1'b1, 5'd0, 0, 1'b1);        // read of an empty table
    put_word(REQ_CLEAR, 8'hff, 1'b1, 5'd31, 0, 1'b0);
    build_pat(3);
    sec[8] = 8'h00;                                         // program number zero skipped
    sec[9] = 8'h00;
    send_section(REQ_PAT, 5'd0, 0, 1'b0);
    est_count = 2;
    types = '{ST_H264_VIDEO, ST_AC3_AUDIO, ST_MPEG2_VIDEO, ST_MPEG1_AUDIO, 8'h86};
    build_pmt(5, types);                                    // last video, first audio win
    send_section(REQ_PMT, 5'd0, 0, 1'b0);
    types = '{ST_EAC3_AUDIO, ST_MPEG1_VIDEO, ST_PES_PRIV, ST_MPEG2_AUDIO};
    build_pmt(4, types);
    send_section(REQ_PMT, 5'd1, 0, 1'b1);                   // mixed byte types
    put_word(REQ_READ, 8'h00, 1'b0, 5'd1, 0, 1'b0);
    put_word(REQ_READ, 8'h00, 1'b0, 5'd31, 0, 1'b0);       // bad index on read
    build_pmt(2, types);
    send_section(REQ_PMT, 5'd31, 0, 1'b0);                  // bad index on pmt
    build_pmt(1, types);
    sec[1][7] = 1'b0;                                       // no syntax bit, still marks done
    send_section(REQ_PMT, 5'd1, 0, 1'b0);
    build_pat(2);
    sec[5][0] = 1'b0;                                       // not current
    send_section(REQ_PAT, 5'd0, 0, 1'b0);
    build_pat(1);
    while (sec.size() > 11) void'(sec.pop_back());         // too short
    send_section(REQ_PAT, 5'd0, 0, 1'b0);
    build_pat(6);
    sec[2] = 8'hff;                                         // walk clamped to received bytes
    send_section(REQ_PAT, 5'd0, 0, 1'b0);
    build_pat(40);                                          // fills the table past capacity
    sec[8] = 8'hff;
    half = sec.size() / 2;
    for (int i = 0; i < sec.size(); i++) begin
      if (i == half) put_word(REQ_CLEAR, 8'h00, 1'b0, 5'd0, 0, 1'b0);  // partial kept
      put_word(REQ_PAT, sec[i], i == sec.size() - 1, 5'd0, 0, 1'b0);
    end
    put_word(REQ_READ, 8'h00, 1'b1, 5'd31, 0, 1'b0);
    sec = {};
    repeat (SECTION_BYTES + 6) sec.push_back(8'($urandom)); // overlong section
    send_section(REQ_PMT, 5'd0, 0, 1'b0);
    put_word(REQ_READ, 8'h5a, 1'b1, 5'd30, 0, 1'b0);
    est_count = 32;

    // random part in four pacing phases
    for (int p = 0; p < 4; p++) begin
      start_words = pending_words.size();
      start_results = built_results;
      put_word(REQ_READ, 8'($urandom), 1'($urandom), pick_index(), idle_of_phase[p], 1'b1);
      while (pending_words.size() - start_words < 113 || built_results - start_results < 15)
      begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: begin
            half = $urandom_range(0, 9);
            build_pat(half);
            damage_section();
            send_section(REQ_PAT, 5'($urandom), idle_of_phase[p], $urandom_range(0, 4) == 0);
            est_count = (est_count + half > MAX_SERVICES) ? MAX_SERVICES : est_count + half;
          end
          8, 9, 10, 11, 12, 13, 14: begin
            types = {};
            build_pmt($urandom_range(0, 6), types);
            damage_section();
            send_section(REQ_PMT, pick_index(), idle_of_phase[p], $urandom_range(0, 4) == 0);
          end
          15, 16, 17:
            put_word(REQ_READ, 8'($urandom), 1'($urandom), pick_index(), idle_of_phase[p],
                     1'b0);
          default: begin
            put_word(REQ_CLEAR, 8'($urandom), 1'($urandom), 5'($urandom), idle_of_phase[p],
                     1'b0);
            est_count = 0;
          end
        endcase
      end
    end

    // drain, then allow the longest parse walk to finish
    while (pending_words.size() > 0 || start || awaited_answers.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, awaited_answers.size());
      errors++;
    end
    $display("covered %0d words (pat/pmt bytes, clears, reads), %0d results checked",
             words_sent, answers_seen);
    $display("%0d field mismatches over four pacing phases", errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
